/* rtl/fpte_pkg.sv */
`timescale 1ns / 1ps

package fpte_pkg;

  localparam int POOL_PAGES        = 64;
  localparam int ENTRIES_PER_TABLE = 512;

  localparam int PAGE_W    = $clog2(POOL_PAGES);
  localparam int NFP_W     = $clog2(POOL_PAGES + 1);
  localparam int IDX_W     = $clog2(ENTRIES_PER_TABLE);
  localparam int ADDR_W    = PAGE_W + IDX_W;
  localparam int MEM_DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;

  localparam int DATA_W    = 64;
  localparam int BASE_W    = 40;
  localparam int VA_W      = 48;
  localparam int RES_W     = 52;
  localparam int FRAME_LSB = 12;
  localparam int LEVEL_W   = 2;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_UNMAP     = 2'd2;
  localparam logic [1:0] OP_NONE      = 2'd3;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_POOL_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OUT_OF_POOL   = 2'd2;

  localparam logic [LEVEL_W-1:0] LEAF_LEVEL = LEVEL_W'(3);

  // Microprogram steps.
  typedef enum logic [2:0] {
    U_IDLE,
    U_READ,
    U_CHECK,
    U_WALK,
    U_LEAF,
    U_CLEAR
  } step_t;

  // Datapath action selected by a control word.
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_PROBE,
    ACT_DESCEND,
    ACT_LEAF,
    ACT_SWEEP
  } act_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_START,
    C_LEAF,
    C_ALLOC,
    C_SWEPT
  } cond_t;

  typedef struct packed {
    logic  mem_rd;
    act_t  act;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // Control store: one word per step. A finishing action overrides the jump
  // and returns the sequencer to U_IDLE.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      U_IDLE:  w = '{mem_rd: 1'b0, act: ACT_ACCEPT,  cond: C_START,
                     tgt_t: U_READ,  tgt_f: U_IDLE};
      U_READ:  w = '{mem_rd: 1'b1, act: ACT_NOP,     cond: C_LEAF,
                     tgt_t: U_LEAF,  tgt_f: U_CHECK};
      U_CHECK: w = '{mem_rd: 1'b0, act: ACT_PROBE,   cond: C_ALLOC,
                     tgt_t: U_WALK,  tgt_f: U_READ};
      U_WALK:  w = '{mem_rd: 1'b0, act: ACT_DESCEND, cond: C_ALWAYS,
                     tgt_t: U_READ,  tgt_f: U_READ};
      U_LEAF:  w = '{mem_rd: 1'b0, act: ACT_LEAF,    cond: C_ALWAYS,
                     tgt_t: U_IDLE,  tgt_f: U_IDLE};
      U_CLEAR: w = '{mem_rd: 1'b0, act: ACT_SWEEP,   cond: C_SWEPT,
                     tgt_t: U_IDLE,  tgt_f: U_CLEAR};
      default: w = '{mem_rd: 1'b0, act: ACT_NOP,     cond: C_ALWAYS,
                     tgt_t: U_IDLE,  tgt_f: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/four_level_page_table_engine_unit.sv */
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in_       start / busy           in_operation, in_virt_addr, in_phys_addr,
//                                  in_entry_flags
// out_      out_valid strobe       out_result_addr, out_status
// cfg_      cfg_wr_en              cfg_wr_data (pool base frame)
//
// Each table level above the leaf takes a memory read, then a test (U_READ,
// U_CHECK), plus a walk step (U_WALK) for each table it allocates; the leaf
// level ends in U_LEAF. The single-port table memory sets this sequence.
// After reset a clearing pass zeroes the 32768-entry store, one entry per
// cycle, with busy held high. The result beat lasts one cycle and cannot be
// held off; busy drops in the same cycle, so the next item may start then.
module four_level_page_table_engine_unit
  import fpte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_operation,
  input  logic [VA_W-1:0]   in_virt_addr,
  input  logic [DATA_W-1:0] in_phys_addr,
  input  logic [DATA_W-1:0] in_entry_flags,
  output logic              out_valid,
  output logic [RES_W-1:0]  out_result_addr,
  output logic [1:0]        out_status,
  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data
);

  localparam logic [ADDR_W-1:0] CLEAR_LAST = ADDR_W'(MEM_DEPTH - 1);
  localparam int                PAD_W      = DATA_W - BASE_W - 1 - FRAME_LSB;

  step_t                upc_r, upc_nxt;
  ucode_t               uc;

  logic [1:0]           op_r, op_nxt;
  logic [VA_W-1:0]      va_r, va_nxt;
  logic [DATA_W-1:0]    phys_r, phys_nxt;
  logic [DATA_W-1:0]    flags_r, flags_nxt;
  logic [PAGE_W-1:0]    page_r, page_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic [DATA_W-1:0]    ent_r, ent_nxt;
  logic [NFP_W-1:0]     nfp_r, nfp_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic [BASE_W-1:0]    base_r;

  logic                 out_valid_r;
  logic [RES_W-1:0]     out_addr_r;
  logic [1:0]           out_status_r;

  logic [DATA_W-1:0]    mem [MEM_DEPTH];
  logic [DATA_W-1:0]    rd_r;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_addr;
  logic [DATA_W-1:0]    mem_wdata;

  logic                 fin;
  logic [RES_W-1:0]     fin_addr;
  logic [1:0]           fin_status;
  logic                 alloc;
  logic                 cond_true;

  logic [IDX_W-1:0]     idx;
  logic [DATA_W-1:0]    chk_ent;
  logic [BASE_W:0]      frame_diff;
  logic                 chk_in_pool;
  logic [PAGE_W-1:0]    chk_off;
  logic [BASE_W:0]      new_frame;
  logic [DATA_W-1:0]    new_ent;
  logic                 exhausted;

  assign uc = ucode_rom(upc_r);

  assign busy            = (upc_r != U_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

  // Table index for the current level.
  always_comb begin
    case (level_r)
      2'd0:    idx = va_r[FRAME_LSB + 3 * IDX_W +: IDX_W];
      2'd1:    idx = va_r[FRAME_LSB + 2 * IDX_W +: IDX_W];
      2'd2:    idx = va_r[FRAME_LSB + IDX_W +: IDX_W];
      default: idx = va_r[FRAME_LSB +: IDX_W];
    endcase
  end

  // Pool check on the entry being walked: a freshly written entry in the walk
  // step, otherwise the word just read. A negative difference sets the top bit
  // of the (BASE_W+1)-bit difference and so falls outside the pool.
  assign chk_ent     = (uc.act == ACT_DESCEND) ? ent_r : rd_r;
  assign frame_diff  = {1'b0, chk_ent[FRAME_LSB +: BASE_W]} - {1'b0, base_r};
  assign chk_in_pool = !frame_diff[BASE_W] &&
                       (frame_diff[BASE_W-1:0] < BASE_W'(POOL_PAGES));
  assign chk_off     = frame_diff[PAGE_W-1:0];

  assign new_frame = {1'b0, base_r} + (BASE_W + 1)'(nfp_r);
  assign new_ent   = {PAD_W'(0), new_frame, FRAME_LSB'(0)} | flags_r;
  assign exhausted = (nfp_r >= NFP_W'(POOL_PAGES));

  // Datapath control decoded from the current control word.
  always_comb begin
    op_nxt     = op_r;
    va_nxt     = va_r;
    phys_nxt   = phys_r;
    flags_nxt  = flags_r;
    page_nxt   = page_r;
    level_nxt  = level_r;
    ent_nxt    = ent_r;
    nfp_nxt    = nfp_r;
    clr_nxt    = clr_r;
    mem_we     = 1'b0;
    mem_addr   = {page_r, idx};
    mem_wdata  = '0;
    fin        = 1'b0;
    fin_addr   = '0;
    fin_status = ST_OK;
    alloc      = 1'b0;
    unique case (uc.act)
      ACT_ACCEPT: begin
        if (start) begin
          op_nxt    = in_operation;
          va_nxt    = in_virt_addr;
          phys_nxt  = in_phys_addr;
          flags_nxt = in_entry_flags;
          page_nxt  = '0;
          level_nxt = '0;
          fin       = (in_operation == OP_NONE);
        end
      end
      ACT_PROBE: begin
        if (rd_r[0]) begin
          if (!chk_in_pool) begin
            fin        = 1'b1;
            fin_status = ST_OUT_OF_POOL;
          end else begin
            page_nxt  = chk_off;
            level_nxt = level_r + LEVEL_W'(1);
          end
        end else begin
          case (op_r)
            OP_MAP: begin
              if (exhausted) begin
                fin        = 1'b1;
                fin_status = ST_POOL_EXHAUSTED;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = new_ent;
                ent_nxt   = new_ent;
                nfp_nxt   = nfp_r + NFP_W'(1);
                alloc     = 1'b1;
              end
            end
            OP_UNMAP: begin
              mem_we = 1'b1;
              fin    = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ACT_DESCEND: begin
        if (!chk_in_pool) begin
          fin        = 1'b1;
          fin_status = ST_OUT_OF_POOL;
        end else begin
          page_nxt  = chk_off;
          level_nxt = level_r + LEVEL_W'(1);
        end
      end
      ACT_LEAF: begin
        fin = 1'b1;
        case (op_r)
          OP_TRANSLATE: fin_addr = {rd_r[FRAME_LSB +: RES_W - FRAME_LSB], FRAME_LSB'(0)};
          OP_MAP: begin
            mem_we    = 1'b1;
            mem_wdata = phys_r | flags_r;
          end
          default: mem_we = 1'b1;
        endcase
      end
      ACT_SWEEP: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + ADDR_W'(1);
      end
      default: ;
    endcase
  end

  // Sequencer: conditional jump, overridden by a finishing action.
  always_comb begin
    unique case (uc.cond)
      C_ALWAYS: cond_true = 1'b1;
      C_START:  cond_true = start;
      C_LEAF:   cond_true = (level_r == LEAF_LEVEL);
      C_ALLOC:  cond_true = alloc;
      C_SWEPT:  cond_true = (clr_r == CLEAR_LAST);
      default:  cond_true = 1'b0;
    endcase
    if (fin) begin
      upc_nxt = U_IDLE;
    end else if (cond_true) begin
      upc_nxt = uc.tgt_t;
    end else begin
      upc_nxt = uc.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (uc.mem_rd) begin
      rd_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_CLEAR;
      clr_r       <= '0;
      nfp_r       <= NFP_W'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      clr_r       <= clr_nxt;
      nfp_r       <= nfp_nxt;
      out_valid_r <= fin;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    va_r    <= va_nxt;
    phys_r  <= phys_nxt;
    flags_r <= flags_nxt;
    page_r  <= page_nxt;
    level_r <= level_nxt;
    ent_r   <= ent_nxt;
    if (fin) begin
      out_addr_r   <= fin_addr;
      out_status_r <= fin_status;
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import fpte_pkg::*;

  localparam logic [DATA_W-1:0] FRAME_MASK  = 64'h000F_FFFF_FFFF_F000;
  localparam int                ROOT_SHIFT  = 39;
  localparam int                STALL_LIMIT = 200000;
  localparam int                MAX_REPORTS = 40;

  typedef struct {
    bit                is_cfg;
    logic [1:0]        op;
    logic [VA_W-1:0]   va;
    logic [DATA_W-1:0] pa;
    logic [DATA_W-1:0] fl;
    logic [BASE_W-1:0] base;
  } table_req_t;

  typedef struct {
    logic [1:0]       op;
    logic [VA_W-1:0]  va;
    logic [RES_W-1:0] addr;
    logic [1:0]       status;
  } walk_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_operation = '0;
  logic [VA_W-1:0]   in_virt_addr = '0;
  logic [DATA_W-1:0] in_phys_addr = '0;
  logic [DATA_W-1:0] in_entry_flags = '0;
  logic              out_valid;
  logic [RES_W-1:0]  out_result_addr;
  logic [1:0]        out_status;
  logic              cfg_wr_en = 1'b0;
  logic [BASE_W-1:0] cfg_wr_data = '0;

  four_level_page_table_engine_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_virt_addr   (in_virt_addr),
    .in_phys_addr   (in_phys_addr),
    .in_entry_flags (in_entry_flags),
    .out_valid      (out_valid),
    .out_result_addr(out_result_addr),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table pool, the page allocator and the base register.
  bit [DATA_W-1:0] shadow_tables [MEM_DEPTH];
  int unsigned     shadow_next_page = 1;
  bit [BASE_W-1:0] shadow_base = '0;

  table_req_t      pending_ops[$];
  walk_result_t    expected_results[$];
  table_req_t      active_req;
  logic [IDX_W-1:0] hot_l4 [8][2];

  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          n_base_writes = 0;
  int          n_ok = 0;
  int          n_exhausted = 0;
  int          n_out_of_pool = 0;
  int          n_frames = 0;
  int          stall_cycles = 0;
  int unsigned idle_left = 0;
  bit          no_idle = 1'b0;

  function automatic walk_result_t walk_page_tables(table_req_t rq);
    walk_result_t    res;
    bit [DATA_W-1:0] ent;
    bit [DATA_W-1:0] pool_off;
    int unsigned     pg;
    int unsigned     slot;
    res.op = rq.op;
    res.va = rq.va;
    res.addr = '0;
    res.status = ST_OK;
    pg = 0;
    if (rq.op == OP_NONE) return res;
    for (int lvl = 0; lvl < 3; lvl++) begin
      slot = pg * ENTRIES_PER_TABLE + rq.va[ROOT_SHIFT - IDX_W * lvl +: IDX_W];
      ent = shadow_tables[slot];
      if (!ent[0]) begin
        if (rq.op == OP_TRANSLATE) return res;
        if (rq.op == OP_UNMAP) begin
          shadow_tables[slot] = '0;
          return res;
        end
        if (shadow_next_page >= POOL_PAGES) begin
          res.status = ST_POOL_EXHAUSTED;
          return res;
        end
        // A new entry is walked even when the flags leave it not present.
        ent = ((64'(shadow_base) + 64'(shadow_next_page)) << FRAME_LSB) | rq.fl;
        shadow_tables[slot] = ent;
        shadow_next_page++;
      end
      // The subtraction wraps, so frames below the base land far outside the pool.
      pool_off = 64'(ent[51:FRAME_LSB]) - 64'(shadow_base);
      if (pool_off >= POOL_PAGES) begin
        res.status = ST_OUT_OF_POOL;
        return res;
      end
      pg = 32'(pool_off);
    end
    slot = pg * ENTRIES_PER_TABLE + rq.va[FRAME_LSB +: IDX_W];
    case (rq.op)
      OP_TRANSLATE: res.addr = RES_W'(shadow_tables[slot] & FRAME_MASK);
      OP_MAP:       shadow_tables[slot] = rq.pa | rq.fl;
      default:      shadow_tables[slot] = '0;
    endcase
    return res;
  endfunction

  function automatic logic [VA_W-1:0] va_of(int l4, int l3, int l2, int l1);
    return {9'(l4), 9'(l3), 9'(l2), 9'(l1), 12'h000};
  endfunction

  // Flags that keep the frame bits clear; the present bit is usually set.
  function automatic logic [DATA_W-1:0] tidy_flags();
    logic [DATA_W-1:0] f;
    f = '0;
    f[63:52] = 12'($urandom);
    f[11:1] = 11'($urandom);
    f[0] = ($urandom_range(0, 9) != 0);
    return f;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 14);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_access(logic [1:0] op, logic [VA_W-1:0] va, logic [DATA_W-1:0] pa,
                              logic [DATA_W-1:0] fl);
    table_req_t rq;
    rq = '{default: '0};
    rq.op = op;
    rq.va = va;
    rq.pa = pa;
    rq.fl = fl;
    pending_ops.push_back(rq);
  endtask

  task automatic queue_base(logic [BASE_W-1:0] base);
    table_req_t rq;
    rq = '{default: '0};
    rq.is_cfg = 1'b1;
    rq.base = base;
    pending_ops.push_back(rq);
  endtask

  // Most accesses go to a few regions of the phase so that tables get reused;
  // the rest use arbitrary addresses and, at times, arbitrary flags.
  function automatic table_req_t make_access(int p);
    table_req_t rq;
    int unsigned r;
    logic [IDX_W-1:0] l3;
    logic [IDX_W-1:0] l2;
    logic [IDX_W-1:0] l1;
    rq = '{default: '0};
    rq.pa = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 85) begin
      l3 = $urandom_range(0, 1) ? 9'd0 : 9'd511;
      l2 = $urandom_range(0, 1) ? 9'd0 : 9'd511;
      l1 = $urandom_range(0, 1) ? 9'($urandom_range(0, 15)) : 9'($urandom_range(496, 511));
      rq.va = {hot_l4[p][$urandom_range(0, 1)], l3, l2, l1, 12'($urandom)};
      r = $urandom_range(0, 99);
      rq.op = (r < 45) ? OP_TRANSLATE : (r < 80) ? OP_MAP : (r < 97) ? OP_UNMAP : OP_NONE;
      rq.fl = tidy_flags();
    end else begin
      rq.va = VA_W'({$urandom, $urandom});
      r = $urandom_range(0, 99);
      rq.op = (r < 50) ? OP_TRANSLATE : (r < 85) ? OP_UNMAP : (r < 90) ? OP_MAP : OP_NONE;
      rq.fl = $urandom_range(0, 1) ? {$urandom, $urandom} : tidy_flags();
    end
    return rq;
  endfunction

  always @(posedge clk) begin
    table_req_t rq;
    logic       start_nx;
    logic       cfg_nx;
    if (rst_n) begin
      start_nx = start;
      cfg_nx = 1'b0;
      if (start && !busy) begin
        expected_results.push_back(walk_page_tables(active_req));
        n_accepted <= n_accepted + 1;
        start_nx = 1'b0;
        if ($urandom_range(0, 63) == 0) no_idle = !no_idle;
        idle_left = no_idle ? 0 : pick_gap();
      end
      if (!start_nx) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_ops.size() != 0) begin
          rq = pending_ops[0];
          if (!rq.is_cfg) begin
            void'(pending_ops.pop_front());
            active_req = rq;
            in_operation <= rq.op;
            in_virt_addr <= rq.va;
            in_phys_addr <= rq.pa;
            in_entry_flags <= rq.fl;
            start_nx = 1'b1;
          end else if (!busy && !start && n_accepted == n_checked) begin
            // The base only changes once every walk in flight has answered.
            void'(pending_ops.pop_front());
            shadow_base = rq.base;
            cfg_wr_data <= rq.base;
            cfg_nx = 1'b1;
            n_base_writes++;
          end
        end
      end
      start <= start_nx;
      cfg_wr_en <= cfg_nx;
    end
  end

  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected: addr %h status %0d",
                   $time, out_result_addr, out_status);
      end else begin
        want = expected_results.pop_front();
        n_checked <= n_checked + 1;
        if (out_result_addr !== want.addr) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: op %0d va %h: result_addr expected %h actual %h",
                     $time, want.op, want.va, want.addr, out_result_addr);
        end
        if (out_status !== want.status) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: op %0d va %h: status expected %0d actual %0d",
                     $time, want.op, want.va, want.status, out_status);
        end
        case (want.status)
          ST_OK:             n_ok++;
          ST_POOL_EXHAUSTED: n_exhausted++;
          default:           n_out_of_pool++;
        endcase
        if (want.addr != '0) n_frames++;
      end
    end
  end

  // The limit covers the clearing pass after reset with a wide margin.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [BASE_W-1:0] base0;
    logic [BASE_W-1:0] phase_base [8];
    int                phase_len [8];
    base0 = 40'h00_0abc_d000;
    phase_base[1] = base0;
    phase_base[2] = '0;
    phase_base[3] = '1;
    phase_base[4] = 40'hFF_FFFF_FFC0;
    phase_base[5] = base0;
    phase_base[6] = {8'($urandom), 32'($urandom)};
    phase_base[7] = base0;
    phase_len[1] = 500;
    phase_len[2] = 250;
    phase_len[3] = 60;
    phase_len[4] = 250;
    phase_len[5] = 400;
    phase_len[6] = 200;
    phase_len[7] = 15;
    for (int p = 1; p < 8; p++) begin
      hot_l4[p][0] = (phase_base[p] == base0) ? 9'd0 : 9'(40 * p + 3);
      hot_l4[p][1] = (phase_base[p] == base0) ? 9'd511 : 9'(40 * p + 23);
    end

    queue_base(base0);
    queue_access(OP_TRANSLATE, '0, '0, '0);
    queue_access(OP_UNMAP, '1, '1, '1);
    queue_access(OP_MAP, '0, '1, 64'h1);
    queue_access(OP_TRANSLATE, '0, '0, '0);
    queue_access(OP_TRANSLATE, 48'h0000_0000_0fff, '1, '1);
    queue_access(OP_MAP, '1, '0, 64'hfff0_0000_0000_0003);
    queue_access(OP_TRANSLATE, '1, '0, '0);
    // A leaf table created through a non-present entry is rebuilt on the next map.
    queue_access(OP_MAP, va_of(0, 0, 1, 0), 64'h1234_5678_9abc_d000, 64'h6);
    queue_access(OP_TRANSLATE, va_of(0, 0, 1, 0), '0, '0);
    queue_access(OP_MAP, va_of(0, 0, 1, 0), 64'h1234_5678_9abc_d000, 64'h1);
    queue_access(OP_TRANSLATE, va_of(0, 0, 1, 0), '0, '0);
    queue_access(OP_UNMAP, '0, '0, '0);
    queue_access(OP_TRANSLATE, '0, '0, '0);
    queue_access(OP_UNMAP, va_of(5, 0, 0, 0), '0, '0);
    queue_access(OP_NONE, '1, '1, '1);
    // Frame bits in the flags point the new root entry outside the pool.
    queue_access(OP_MAP, va_of(7, 0, 0, 0), '0, 64'h0000_0000_0040_0001);
    queue_access(OP_TRANSLATE, va_of(7, 0, 0, 0), '0, '0);
    queue_access(OP_UNMAP, va_of(7, 0, 0, 0), '0, '0);
    queue_access(OP_MAP, va_of(0, 0, 0, 3), '1, '1);
    queue_access(OP_TRANSLATE, va_of(0, 0, 0, 3), '0, '0);
    queue_access(OP_TRANSLATE, 48'h8000_0000_0000, '0, '0);
    queue_access(OP_MAP, va_of(0, 0, 0, 1), 64'h8000_0000_0000_0000, '0);
    queue_access(OP_TRANSLATE, va_of(0, 0, 0, 1), '0, '0);

    for (int p = 1; p < 8; p++) begin
      queue_base(phase_base[p]);
      // The last phase maps scattered addresses until the pool runs dry.
      if (p == 7)
        repeat (45) queue_access(OP_MAP, VA_W'({$urandom, $urandom}),
                                 {$urandom, $urandom}, tidy_flags() | 64'h1);
      repeat (phase_len[p]) pending_ops.push_back(make_access(p));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_ops.size() != 0 || start || n_accepted != n_checked) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("Checked %0d walks across %0d pool base settings, zero and the top frame included.",
             n_checked, n_base_writes);
    $display("Outcomes: %0d ok, %0d pool exhausted, %0d outside pool; %0d returned a frame.",
             n_ok, n_exhausted, n_out_of_pool, n_frames);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* four_level_page_table_engine_unit.f */
rtl/fpte_pkg.sv
rtl/four_level_page_table_engine_unit.sv
sim/tb.sv
